// ----- rtl/rfc_pkg.sv -----
// ============================================================================
// rfc_pkg
// Shared types and constants for the rotating frame compositor: item
// layouts, pixel kinds, modes, register map and blend masks.
// ============================================================================
package rfc_pkg;

    // Item command codes.
    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_BLEND = 1'b1;

    // Pixel kinds carried by map and blend results.
    typedef enum logic [2:0] {
        KIND_BG     = 3'd0,
        KIND_COPY_A = 3'd1,
        KIND_COPY_B = 3'd2,
        KIND_SCRIM  = 3'd3,
        KIND_FADE   = 3'd4
    } t_kind;

    // Composition modes; the three unused codes behave as plain.
    typedef enum logic [2:0] {
        MODE_PLAIN      = 3'd0,
        MODE_SLIDE_FWD  = 3'd1,
        MODE_SLIDE_BACK = 3'd2,
        MODE_SHEET      = 3'd3,
        MODE_FADE       = 3'd4
    } t_mode;

    // Register indexes, one 32-bit word each.
    typedef enum logic [2:0] {
        REG_MODE         = 3'd0,
        REG_ROTATED_FLIP = 3'd1,
        REG_SHIFT_X      = 3'd2,
        REG_SHIFT_Y      = 3'd3,
        REG_OFFSET       = 3'd4,
        REG_BLEND_LEVEL  = 3'd5,
        REG_BG_COLOR     = 3'd6,
        REG_PIN_ROW      = 3'd7
    } t_reg_idx;

    localparam int          PADDR_W       = 5;
    localparam int          ADDR_W        = 18;
    localparam logic [8:0]  PIN_ROW_RESET = 9'd320;

    // Per-channel shift masks for RGB565 quarters and halves.
    localparam logic [15:0] QUARTER_MASK  = 16'h39E7;
    localparam logic [15:0] HALF_MASK     = 16'h7BEF;

    // Configuration register bank.
    typedef struct packed {
        logic [2:0]  mode;
        logic        rotated_flip;
        logic [9:0]  shift_x;
        logic [9:0]  shift_y;
        logic [9:0]  offset_amount;
        logic [1:0]  blend_level;
        logic [15:0] bg_color;
        logic [8:0]  pin_row;
    } t_cfg;

    // Input item.
    typedef struct packed {
        logic        cmd;
        logic [8:0]  panel_x;
        logic [8:0]  panel_y;
        logic [2:0]  kind_in;
        logic [15:0] pixel_a;
        logic [15:0] pixel_b;
    } t_in_item;

    // Result item.
    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr_a;
        logic [ADDR_W-1:0]  addr_b;
        logic [15:0]        color;
    } t_out_item;

endpackage

// ----- rtl/rfc_stream_if.sv -----
// ============================================================================
// rfc_stream_if
// Valid/ready channels for compositor input items and result items.
// ============================================================================
interface rfc_in_if;
    logic               valid;
    logic               ready;
    rfc_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rfc_out_if;
    logic               valid;
    logic               ready;
    rfc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rfc_map.sv -----
// ============================================================================
// rfc_map
// Panel coordinate to source pixel mapping: rotation, shift, bounds and the
// slide, sheet and fade selections. Produces the kind and the source row and
// column for each frame; an unused frame gets row and column zero.
// ============================================================================
module rfc_map #(
    parameter int SRC_WIDTH  = 480,
    parameter int SRC_HEIGHT = 320
) (
    input  rfc_pkg::t_cfg                    i_cfg,
    input  logic [8:0]                       i_panel_x,
    input  logic [8:0]                       i_panel_y,
    output rfc_pkg::t_kind                   o_kind,
    output logic [$clog2(SRC_HEIGHT)-1:0]    o_row_a,
    output logic [$clog2(SRC_WIDTH)-1:0]     o_col_a,
    output logic [$clog2(SRC_HEIGHT)-1:0]    o_row_b,
    output logic [$clog2(SRC_WIDTH)-1:0]     o_col_b
);

    localparam int RW      = $clog2(SRC_HEIGHT);
    localparam int CW      = $clog2(SRC_WIDTH);
    localparam int MAX_DIM = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int SGW     = ($clog2(MAX_DIM) + 3 > 12) ? $clog2(MAX_DIM) + 3 : 12;

    localparam logic signed [SGW-1:0] W_S = SGW'(SRC_WIDTH);
    localparam logic signed [SGW-1:0] H_S = SGW'(SRC_HEIGHT);
    localparam logic signed [SGW-1:0] ONE = SGW'(1);

    logic signed [SGW-1:0] px_s, py_s, lx, ly, sx, sy;
    logic signed [SGW-1:0] shx_s, shy_s, ofs_s, pin_s;
    logic signed [SGW-1:0] off, split, top, sheet_row;
    logic                  in_panel, in_src;

    // Widen every operand to one signed width.
    assign px_s  = $signed({{(SGW-9){1'b0}}, i_panel_x});
    assign py_s  = $signed({{(SGW-9){1'b0}}, i_panel_y});
    assign shx_s = $signed({{(SGW-10){i_cfg.shift_x[9]}}, i_cfg.shift_x});
    assign shy_s = $signed({{(SGW-10){i_cfg.shift_y[9]}}, i_cfg.shift_y});
    assign ofs_s = $signed({{(SGW-10){1'b0}}, i_cfg.offset_amount});
    assign pin_s = $signed({{(SGW-9){1'b0}}, i_cfg.pin_row});

    // Rotation into the landscape frame, then the source shift.
    assign lx = i_cfg.rotated_flip ? (W_S - ONE - py_s) : py_s;
    assign ly = i_cfg.rotated_flip ? px_s : (H_S - ONE - px_s);
    assign sx = lx - shx_s;
    assign sy = ly - shy_s;

    assign in_panel = (px_s < H_S) && (py_s < W_S);
    assign in_src   = (sx >= 0) && (sx < W_S) && (sy >= 0) && (sy < H_S);

    // Slide split point and sheet top edge.
    assign off       = (ofs_s > W_S) ? W_S : ofs_s;
    assign split     = W_S - off;
    assign top       = H_S - ofs_s;
    assign sheet_row = sy - top;

    // Kind and source coordinates per mode.
    always_comb begin
        o_kind  = rfc_pkg::KIND_BG;
        o_row_a = '0;
        o_col_a = '0;
        o_row_b = '0;
        o_col_b = '0;
        if (in_panel && in_src) begin
            case (i_cfg.mode)
                rfc_pkg::MODE_SLIDE_FWD, rfc_pkg::MODE_SLIDE_BACK: begin
                    if (ly >= pin_s) begin
                        o_kind  = rfc_pkg::KIND_COPY_B;
                        o_row_b = RW'(sy);
                        o_col_b = CW'(sx);
                    end else if (i_cfg.mode == rfc_pkg::MODE_SLIDE_FWD) begin
                        if (sx < split) begin
                            o_kind  = rfc_pkg::KIND_COPY_A;
                            o_row_a = RW'(sy);
                            o_col_a = CW'(sx + off);
                        end else begin
                            o_kind  = rfc_pkg::KIND_COPY_B;
                            o_row_b = RW'(sy);
                            o_col_b = CW'(sx - split);
                        end
                    end else begin
                        if (sx < off) begin
                            o_kind  = rfc_pkg::KIND_COPY_B;
                            o_row_b = RW'(sy);
                            o_col_b = CW'(sx + split);
                        end else begin
                            o_kind  = rfc_pkg::KIND_COPY_A;
                            o_row_a = RW'(sy);
                            o_col_a = CW'(sx - off);
                        end
                    end
                end
                rfc_pkg::MODE_SHEET: begin
                    if (sy < top) begin
                        o_kind  = rfc_pkg::KIND_SCRIM;
                        o_row_a = RW'(sy);
                        o_col_a = CW'(sx);
                    end else if (sheet_row < H_S) begin
                        o_kind  = rfc_pkg::KIND_COPY_B;
                        o_row_b = RW'(sheet_row);
                        o_col_b = CW'(sx);
                    end
                end
                rfc_pkg::MODE_FADE: begin
                    o_kind  = rfc_pkg::KIND_FADE;
                    o_row_a = RW'(sy);
                    o_col_a = CW'(sx);
                    o_row_b = RW'(sy);
                    o_col_b = CW'(sx);
                end
                default: begin
                    o_kind  = rfc_pkg::KIND_COPY_A;
                    o_row_a = RW'(sy);
                    o_col_a = CW'(sx);
                end
            endcase
        end
    end

endmodule

// ----- rtl/rotating_frame_compositor_core.sv -----
// ============================================================================
// rotating_frame_compositor_core
// Portrait panel pixel compositor over two landscape RGB565 frames: maps
// panel coordinates to source word addresses and blends fetched pixels.
// ============================================================================
//
//  Channel   Dir  Handshake             Payload
//  i_in      in   valid/ready           cmd, panel_x, panel_y, kind_in,
//                                       pixel_a, pixel_b
//  o_out     out  valid/ready           kind, addr_a, addr_b, color
//  APB       in   psel/penable/pwrite   paddr, pwdata, prdata (pready = 1)
//
//  One item per clock while the output is not stalled. An input register
//  is followed by the map or blend logic and the row times width address
//  multiply, which feed the result register. Both stages advance together
//  whenever the result register is empty or being taken, so a stalled
//  output holds the input stage and i_in.ready drops. Synchronous active-low
//  reset clears the stage valid bits and loads the register reset values.
//
module rotating_frame_compositor_core #(
    parameter int SRC_WIDTH  = 480,
    parameter int SRC_HEIGHT = 320
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rfc_in_if.sink                        i_in,
    rfc_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int RW     = $clog2(SRC_HEIGHT);
    localparam int CW     = $clog2(SRC_WIDTH);
    localparam int PROD_W = RW + CW + 1;

    rfc_pkg::t_cfg      r_cfg;
    rfc_pkg::t_in_item  r_in;
    logic               r_s1_valid;
    rfc_pkg::t_out_item r_out;
    logic               r_out_valid;
    rfc_pkg::t_out_item n_out;

    logic               w_adv;
    logic               w_wr;
    rfc_pkg::t_reg_idx  w_idx;
    rfc_pkg::t_kind     w_map_kind;
    logic [RW-1:0]      w_row_a, w_row_b;
    logic [CW-1:0]      w_col_a, w_col_b;
    logic [15:0]        w_bg_be;
    logic [15:0]        w_blend;
    logic [15:0]        w_a, w_b;

    function automatic logic [15:0] swap16(input logic [15:0] c);
        return {c[7:0], c[15:8]};
    endfunction

    function automatic logic [15:0] quarter(input logic [15:0] c);
        return (c >> 2) & rfc_pkg::QUARTER_MASK;
    endfunction

    function automatic logic [15:0] half(input logic [15:0] c);
        return (c >> 1) & rfc_pkg::HALF_MASK;
    endfunction

    // Register port: writes land on the access phase, reads are immediate.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = rfc_pkg::t_reg_idx'(paddr[rfc_pkg::PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: '0, rotated_flip: 1'b0, shift_x: '0, shift_y: '0,
                       offset_amount: '0, blend_level: '0, bg_color: '0,
                       pin_row: rfc_pkg::PIN_ROW_RESET};
        end else if (w_wr) begin
            unique case (w_idx)
                rfc_pkg::REG_MODE:         r_cfg.mode          <= pwdata[2:0];
                rfc_pkg::REG_ROTATED_FLIP: r_cfg.rotated_flip  <= pwdata[0];
                rfc_pkg::REG_SHIFT_X:      r_cfg.shift_x       <= pwdata[9:0];
                rfc_pkg::REG_SHIFT_Y:      r_cfg.shift_y       <= pwdata[9:0];
                rfc_pkg::REG_OFFSET:       r_cfg.offset_amount <= pwdata[9:0];
                rfc_pkg::REG_BLEND_LEVEL:  r_cfg.blend_level   <= pwdata[1:0];
                rfc_pkg::REG_BG_COLOR:     r_cfg.bg_color      <= pwdata[15:0];
                rfc_pkg::REG_PIN_ROW:      r_cfg.pin_row       <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            rfc_pkg::REG_MODE:         prdata = 32'(r_cfg.mode);
            rfc_pkg::REG_ROTATED_FLIP: prdata = 32'(r_cfg.rotated_flip);
            rfc_pkg::REG_SHIFT_X:      prdata = 32'(r_cfg.shift_x);
            rfc_pkg::REG_SHIFT_Y:      prdata = 32'(r_cfg.shift_y);
            rfc_pkg::REG_OFFSET:       prdata = 32'(r_cfg.offset_amount);
            rfc_pkg::REG_BLEND_LEVEL:  prdata = 32'(r_cfg.blend_level);
            rfc_pkg::REG_BG_COLOR:     prdata = 32'(r_cfg.bg_color);
            rfc_pkg::REG_PIN_ROW:      prdata = 32'(r_cfg.pin_row);
            default:                   prdata = '0;
        endcase
    end

    // Pipeline advance: both stages move when the result slot frees up.
    assign w_adv       = !r_out_valid || o_out.ready;
    assign i_in.ready  = w_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_in.valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in  <= i_in.data;
            r_out <= n_out;
        end
    end

    // Coordinate mapping for map transactions.
    rfc_map #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_map (
        .i_cfg      (r_cfg),
        .i_panel_x  (r_in.panel_x),
        .i_panel_y  (r_in.panel_y),
        .o_kind     (w_map_kind),
        .o_row_a    (w_row_a),
        .o_col_a    (w_col_a),
        .o_row_b    (w_row_b),
        .o_col_b    (w_col_b)
    );

    // Blend of the two fetched pixels in native channel order.
    assign w_bg_be = swap16(r_cfg.bg_color);
    assign w_a     = swap16(r_in.pixel_a);
    assign w_b     = swap16(r_in.pixel_b);

    always_comb begin
        w_blend = w_bg_be;
        case (r_in.kind_in)
            rfc_pkg::KIND_COPY_A: w_blend = r_in.pixel_a;
            rfc_pkg::KIND_COPY_B: w_blend = r_in.pixel_b;
            rfc_pkg::KIND_SCRIM: begin
                case (r_cfg.blend_level)
                    2'd0:    w_blend = r_in.pixel_a;
                    2'd1:    w_blend = swap16(w_a - quarter(w_a));
                    default: w_blend = swap16(half(w_a));
                endcase
            end
            rfc_pkg::KIND_FADE: begin
                case (r_cfg.blend_level)
                    2'd0, 2'd1: w_blend = swap16(w_a - quarter(w_a) + quarter(w_b));
                    2'd2:       w_blend = swap16(half(w_a) + half(w_b));
                    default:    w_blend = swap16(quarter(w_a) + w_b - quarter(w_b));
                endcase
            end
            default: w_blend = w_bg_be;
        endcase
    end

    // Result assembly; addresses are row times width plus column.
    always_comb begin
        n_out = '0;
        if (r_in.cmd == rfc_pkg::CMD_MAP) begin
            n_out.kind   = w_map_kind;
            n_out.addr_a = rfc_pkg::ADDR_W'(PROD_W'(w_row_a) * PROD_W'(SRC_WIDTH)
                                            + PROD_W'(w_col_a));
            n_out.addr_b = rfc_pkg::ADDR_W'(PROD_W'(w_row_b) * PROD_W'(SRC_WIDTH)
                                            + PROD_W'(w_col_b));
            n_out.color  = w_bg_be;
        end else begin
            n_out.kind   = (r_in.kind_in > rfc_pkg::KIND_FADE) ? rfc_pkg::KIND_BG
                                                 : rfc_pkg::t_kind'(r_in.kind_in);
            n_out.color  = w_blend;
        end
    end

    // A stalled result register must hold the input stage off.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while result register is stalled");

    // An accepted transaction occupies the input stage on the next cycle.
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_s1_valid)
        else $error("accepted transaction lost from input stage");

    // Background results never carry a source address.
    a_bg_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.kind == rfc_pkg::KIND_BG)
            |-> (o_out.data.addr_a == '0 && o_out.data.addr_b == '0))
        else $error("background result with nonzero address");

    // Copy-a results never carry a frame b address.
    a_copy_single_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.kind == rfc_pkg::KIND_COPY_A)
            |-> (o_out.data.addr_b == '0))
        else $error("copy-a result with frame b address");

endmodule

// ----- bench/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the rotating frame compositor core. A clocked
// driver feeds map and blend transactions from a job queue. A clocked
// monitor compares every result with a local pixel predictor. Register
// settings change over the APB port between phases, while the core is idle.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SRC_W          = 480;
    localparam int SRC_H          = 320;
    localparam int GAP_PERCENT    = 13;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_PHASES     = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [rfc_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rfc_in_if  in_if ();
    rfc_out_if out_if ();

    // Shadow copy of the register bank used by the predictor.
    rfc_pkg::t_cfg       shadow_cfg;
    rfc_pkg::t_in_item   pixel_jobs[$];
    rfc_pkg::t_out_item  expected_pixels[$];
    int                  mismatch_count = 0;
    logic                gaps_on = 1'b1;

    rotating_frame_compositor_core #(
        .SRC_WIDTH  (SRC_W),
        .SRC_HEIGHT (SRC_H)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Pixel predictor.
    // ------------------------------------------------------------------------
    function automatic logic [15:0] swap_bytes(logic [15:0] c);
        return {c[7:0], c[15:8]};
    endfunction

    function automatic logic [rfc_pkg::ADDR_W-1:0] word_address(int row, int col);
        int linear;
        linear = row * SRC_W + col;
        return linear[rfc_pkg::ADDR_W-1:0];
    endfunction

    // Darken a big-endian pixel by a quarter or a half per channel; level zero keeps it.
    function automatic logic [15:0] scrim_pixel(logic [15:0] be, logic [1:0] lvl);
        logic [15:0] c;
        if (lvl == 2'd0) begin
            return be;
        end
        c = swap_bytes(be);
        if (lvl == 2'd1) begin
            c = c - ((c >> 2) & rfc_pkg::QUARTER_MASK);
        end else begin
            c = (c >> 1) & rfc_pkg::HALF_MASK;
        end
        return swap_bytes(c);
    endfunction

    // Mix two big-endian pixels at 75/25, 50/50 or 25/75.
    function automatic logic [15:0] fade_pixel(logic [15:0] a_be, logic [15:0] b_be,
                                               logic [1:0] lvl);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        a = swap_bytes(a_be);
        b = swap_bytes(b_be);
        if (lvl <= 2'd1) begin
            c = a - ((a >> 2) & rfc_pkg::QUARTER_MASK) + ((b >> 2) & rfc_pkg::QUARTER_MASK);
        end else if (lvl == 2'd2) begin
            c = ((a >> 1) & rfc_pkg::HALF_MASK) + ((b >> 1) & rfc_pkg::HALF_MASK);
        end else begin
            c = ((a >> 2) & rfc_pkg::QUARTER_MASK) + b - ((b >> 2) & rfc_pkg::QUARTER_MASK);
        end
        return swap_bytes(c);
    endfunction

    function automatic rfc_pkg::t_out_item compose_pixel(rfc_pkg::t_in_item it);
        rfc_pkg::t_out_item res;
        int        lx;
        int        ly;
        int        sx;
        int        sy;
        int        off;
        int        split;
        int        top;
        res.kind   = rfc_pkg::KIND_BG;
        res.addr_a = '0;
        res.addr_b = '0;
        res.color  = swap_bytes(shadow_cfg.bg_color);
        if (it.cmd == rfc_pkg::CMD_MAP) begin
            if (it.panel_x < SRC_H && it.panel_y < SRC_W) begin
                // Rotate the panel coordinate into the landscape frame.
                if (shadow_cfg.rotated_flip) begin
                    lx = SRC_W - 1 - int'(it.panel_y);
                    ly = int'(it.panel_x);
                end else begin
                    lx = int'(it.panel_y);
                    ly = SRC_H - 1 - int'(it.panel_x);
                end
                sx = lx - int'($signed(shadow_cfg.shift_x));
                sy = ly - int'($signed(shadow_cfg.shift_y));
                if (sx >= 0 && sx < SRC_W && sy >= 0 && sy < SRC_H) begin
                    case (shadow_cfg.mode)
                        rfc_pkg::MODE_SLIDE_FWD, rfc_pkg::MODE_SLIDE_BACK: begin
                            off = (int'(shadow_cfg.offset_amount) > SRC_W) ?
                                  SRC_W : int'(shadow_cfg.offset_amount);
                            split = SRC_W - off;
                            // The pinned bottom band never moves.
                            if (ly >= int'(shadow_cfg.pin_row)) begin
                                res.kind   = rfc_pkg::KIND_COPY_B;
                                res.addr_b = word_address(sy, sx);
                            end else if (shadow_cfg.mode == rfc_pkg::MODE_SLIDE_FWD) begin
                                if (sx < split) begin
                                    res.kind   = rfc_pkg::KIND_COPY_A;
                                    res.addr_a = word_address(sy, sx + off);
                                end else begin
                                    res.kind   = rfc_pkg::KIND_COPY_B;
                                    res.addr_b = word_address(sy, sx - split);
                                end
                            end else begin
                                if (sx < off) begin
                                    res.kind   = rfc_pkg::KIND_COPY_B;
                                    res.addr_b = word_address(sy, sx + split);
                                end else begin
                                    res.kind   = rfc_pkg::KIND_COPY_A;
                                    res.addr_a = word_address(sy, sx - off);
                                end
                            end
                        end
                        rfc_pkg::MODE_SHEET: begin
                            // Rows past the sheet bottom show the background.
                            top = SRC_H - int'(shadow_cfg.offset_amount);
                            if (sy < top) begin
                                res.kind   = rfc_pkg::KIND_SCRIM;
                                res.addr_a = word_address(sy, sx);
                            end else if (sy - top < SRC_H) begin
                                res.kind   = rfc_pkg::KIND_COPY_B;
                                res.addr_b = word_address(sy - top, sx);
                            end
                        end
                        rfc_pkg::MODE_FADE: begin
                            res.kind   = rfc_pkg::KIND_FADE;
                            res.addr_a = word_address(sy, sx);
                            res.addr_b = word_address(sy, sx);
                        end
                        default: begin
                            res.kind   = rfc_pkg::KIND_COPY_A;
                            res.addr_a = word_address(sy, sx);
                        end
                    endcase
                end
            end
        end else begin
            // Unknown kinds fall back to the background color.
            case (it.kind_in)
                rfc_pkg::KIND_COPY_A: begin
                    res.kind  = rfc_pkg::KIND_COPY_A;
                    res.color = it.pixel_a;
                end
                rfc_pkg::KIND_COPY_B: begin
                    res.kind  = rfc_pkg::KIND_COPY_B;
                    res.color = it.pixel_b;
                end
                rfc_pkg::KIND_SCRIM: begin
                    res.kind  = rfc_pkg::KIND_SCRIM;
                    res.color = scrim_pixel(it.pixel_a, shadow_cfg.blend_level);
                end
                rfc_pkg::KIND_FADE: begin
                    res.kind  = rfc_pkg::KIND_FADE;
                    res.color = fade_pixel(it.pixel_a, it.pixel_b,
                                           shadow_cfg.blend_level);
                end
                default: begin
                end
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: presents queued jobs with random gaps.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_pixels.push_back(compose_pixel(in_if.data));
            end
            if (!in_if.valid || in_if.ready) begin
                if (pixel_jobs.size() > 0 &&
                    !(gaps_on && $urandom_range(0, 99) < GAP_PERCENT)) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= pixel_jobs.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: random back-pressure and field-by-field compare.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rfc_pkg::t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= gaps_on ? ($urandom_range(0, 99) >= GAP_PERCENT) : 1'b1;
            if (out_if.valid && out_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected result, kind", out_if.data.kind, '0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_if.data.kind !== want.kind)
                        report_mismatch("kind", out_if.data.kind, want.kind);
                    if (out_if.data.addr_a !== want.addr_a)
                        report_mismatch("addr_a", out_if.data.addr_a, want.addr_a);
                    if (out_if.data.addr_b !== want.addr_b)
                        report_mismatch("addr_b", out_if.data.addr_b, want.addr_b);
                    if (out_if.data.color !== want.color)
                        report_mismatch("color", out_if.data.color, want.color);
                end
            end
        end
    end

    // Ends the run when no transaction has moved for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Register writes and job generation.
    // ------------------------------------------------------------------------
    task automatic cfg_write(rfc_pkg::t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            rfc_pkg::REG_MODE:         shadow_cfg.mode          = value[2:0];
            rfc_pkg::REG_ROTATED_FLIP: shadow_cfg.rotated_flip  = value[0];
            rfc_pkg::REG_SHIFT_X:      shadow_cfg.shift_x       = value[9:0];
            rfc_pkg::REG_SHIFT_Y:      shadow_cfg.shift_y       = value[9:0];
            rfc_pkg::REG_OFFSET:       shadow_cfg.offset_amount = value[9:0];
            rfc_pkg::REG_BLEND_LEVEL:  shadow_cfg.blend_level   = value[1:0];
            rfc_pkg::REG_BG_COLOR:     shadow_cfg.bg_color      = value[15:0];
            rfc_pkg::REG_PIN_ROW:      shadow_cfg.pin_row       = value[8:0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_settings(logic [2:0] mode, logic flip, logic [9:0] sh_x,
                                  logic [9:0] sh_y, logic [9:0] off, logic [1:0] lvl,
                                  logic [15:0] bg, logic [8:0] pin);
        cfg_write(rfc_pkg::REG_MODE, 32'(mode));
        cfg_write(rfc_pkg::REG_ROTATED_FLIP, 32'(flip));
        cfg_write(rfc_pkg::REG_SHIFT_X, 32'(sh_x));
        cfg_write(rfc_pkg::REG_SHIFT_Y, 32'(sh_y));
        cfg_write(rfc_pkg::REG_OFFSET, 32'(off));
        cfg_write(rfc_pkg::REG_BLEND_LEVEL, 32'(lvl));
        cfg_write(rfc_pkg::REG_BG_COLOR, 32'(bg));
        cfg_write(rfc_pkg::REG_PIN_ROW, 32'(pin));
    endtask

    // Waits until every queued job has been taken and every result checked.
    task automatic wait_until_drained();
        @(negedge i_clk);
        while (pixel_jobs.size() != 0 || in_if.valid || expected_pixels.size() != 0)
            @(negedge i_clk);
    endtask

    // Unused fields carry random bits so that every input bit toggles.
    function automatic rfc_pkg::t_in_item random_fill();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(rfc_pkg::t_in_item)-1:0];
    endfunction

    task automatic push_map(int px, int py);
        rfc_pkg::t_in_item it;
        it         = random_fill();
        it.cmd     = rfc_pkg::CMD_MAP;
        it.panel_x = px[8:0];
        it.panel_y = py[8:0];
        pixel_jobs.push_back(it);
    endtask

    task automatic push_blend(rfc_pkg::t_kind k, logic [15:0] pa, logic [15:0] pb);
        rfc_pkg::t_in_item it;
        it         = random_fill();
        it.cmd     = rfc_pkg::CMD_BLEND;
        it.kind_in = k;
        it.pixel_a = pa;
        it.pixel_b = pb;
        pixel_jobs.push_back(it);
    endtask

    // Mostly on-panel coordinates, some anywhere, the rest blends of any kind.
    task automatic push_random_jobs(int count);
        rfc_pkg::t_in_item it;
        int       pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                push_map($urandom_range(0, SRC_H - 1), $urandom_range(0, SRC_W - 1));
            end else if (pick < 68) begin
                push_map($urandom_range(0, 511), $urandom_range(0, 511));
            end else begin
                it     = random_fill();
                it.cmd = rfc_pkg::CMD_BLEND;
                pixel_jobs.push_back(it);
            end
        end
    endtask

    function automatic logic [9:0] small_shift();
        int s;
        s = int'($urandom_range(0, 80)) - 40;
        return s[9:0];
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        shadow_cfg               = '0;
        shadow_cfg.pin_row       = rfc_pkg::PIN_ROW_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed jobs under the reset settings: panel corners, off-panel
        // coordinates and every blend kind with extreme pixels.
        @(negedge i_clk);
        push_map(0, 0);
        push_map(SRC_H - 1, SRC_W - 1);
        push_map(SRC_H - 1, 0);
        push_map(0, SRC_W - 1);
        push_map(SRC_H, 0);
        push_map(0, SRC_W);
        push_map(511, 511);
        push_map(160, 240);
        push_blend(rfc_pkg::KIND_BG, 16'hFFFF, 16'h0000);
        push_blend(rfc_pkg::KIND_COPY_A, 16'hFFFF, 16'h0000);
        push_blend(rfc_pkg::KIND_COPY_B, 16'h0000, 16'hFFFF);
        push_blend(rfc_pkg::KIND_SCRIM, 16'hFFFF, 16'hFFFF);
        push_blend(rfc_pkg::KIND_FADE, 16'hFFFF, 16'h0000);
        push_blend(rfc_pkg::KIND_FADE, 16'h0000, 16'hFFFF);
        push_blend(rfc_pkg::t_kind'(3'd5), 16'h1234, 16'h5678);
        push_blend(rfc_pkg::t_kind'(3'd6), 16'hFFFF, 16'hFFFF);
        push_blend(rfc_pkg::t_kind'(3'd7), 16'h0000, 16'h0000);
        push_blend(rfc_pkg::KIND_SCRIM, 16'h8000, 16'h0001);
        wait_until_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                // Extremes: most negative and positive shifts, clamped slide.
                8: apply_settings(rfc_pkg::MODE_SLIDE_BACK, 1'b1, 10'h200, 10'h1FF,
                                  10'h3FF, 2'd3, 16'hFFFF, 9'h1FF);
                // Sheet with overshoot below the bottom edge, no gaps.
                9: apply_settings(rfc_pkg::MODE_SHEET, 1'b0, 10'd0, 10'd0, 10'd400,
                                  2'd2, 16'h0000, 9'd0);
                // Slide by exactly the width, no gaps.
                10: apply_settings(rfc_pkg::MODE_SLIDE_FWD, 1'b0, small_shift(),
                                   small_shift(), 10'(SRC_W), 2'd1, 16'($urandom),
                                   9'd200);
                // Every register bit random.
                11: apply_settings(3'($urandom), 1'($urandom), 10'($urandom),
                                   10'($urandom), 10'($urandom), 2'($urandom),
                                   16'($urandom), 9'($urandom));
                // One phase per mode code, unused codes included.
                default: apply_settings(3'(p), 1'(p), small_shift(), small_shift(),
                                        10'($urandom_range(0, 700)),
                                        2'($urandom_range(0, 3)), 16'($urandom),
                                        9'($urandom_range(0, SRC_H + 10)));
            endcase
            gaps_on = !(p == 9 || p == 10);
            @(negedge i_clk);
            if (p == 5) begin
                // Hold the sender until every result is back, then resume.
                push_random_jobs(PHASE_ITEMS / 2);
                wait_until_drained();
                push_random_jobs(PHASE_ITEMS / 2);
            end else begin
                push_random_jobs(PHASE_ITEMS);
            end
            wait_until_drained();
        end

        gaps_on = 1'b1;
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
